[hdl/pfig_pkg.sv]
package pfig_pkg;

    localparam int TICK_W    = 24;
    localparam int ELAPSED_W = 29;
    localparam int CHAN_W    = 3;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [TICK_W-1:0]    FRAME_RESET = TICK_W'(9000 * 20);
    localparam logic [TICK_W-1:0]    GAP_RESET   = TICK_W'(4500);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_EXPIRE = 1'b1
    } kind_t;

    // Word index of a configuration register, taken from paddr[2].
    typedef enum logic {
        REG_FRAME_LENGTH = 1'b0,
        REG_GAP_LENGTH   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] interval_ticks;
        logic              pin_level;
        logic              sync_phase;
        logic              frame_overrun;
    } result_t;

    typedef struct packed {
        result_t              res;
        logic                 high_next;
        logic                 ptr_advance;
        logic                 ptr_wrap;
        logic [ELAPSED_W-1:0] elapsed_next;
    } step_t;

endpackage

[hdl/pfig_step.sv]
module pfig_step (
    input  logic                           in_high_phase,
    input  logic                           last_done,
    input  logic [pfig_pkg::TICK_W-1:0]    chan_width,
    input  logic [pfig_pkg::ELAPSED_W-1:0] elapsed,
    input  logic [pfig_pkg::TICK_W-1:0]    frame_length,
    input  logic [pfig_pkg::TICK_W-1:0]    gap_length,
    output pfig_pkg::step_t                step
);

    logic [pfig_pkg::TICK_W-1:0]    high_ticks;
    logic [pfig_pkg::TICK_W-1:0]    add_ticks;
    logic [pfig_pkg::ELAPSED_W:0]   sum;
    logic                           overrun;

    // A channel width shorter than the gap still gives a full gap of high time.
    assign high_ticks = (chan_width < gap_length) ? gap_length : (chan_width - gap_length);
    assign add_ticks  = in_high_phase ? high_ticks : gap_length;
    assign sum        = {1'b0, elapsed} + (pfig_pkg::ELAPSED_W + 1)'(add_ticks);
    assign overrun    = elapsed >= pfig_pkg::ELAPSED_W'(frame_length);

    always_comb begin
        step = '0;
        if (!in_high_phase) begin
            step.res.interval_ticks = gap_length;
            step.high_next          = 1'b1;
        end else if (!last_done) begin
            step.res.interval_ticks = high_ticks;
            step.res.pin_level      = 1'b1;
            step.ptr_advance        = 1'b1;
        end else begin
            step.res.interval_ticks = overrun ? '0 : (frame_length - elapsed[pfig_pkg::TICK_W-1:0]);
            step.res.pin_level      = 1'b1;
            step.res.sync_phase     = 1'b1;
            step.res.frame_overrun  = overrun;
            step.ptr_wrap           = 1'b1;
        end

        if (last_done && in_high_phase) begin
            step.elapsed_next = '0;
        end else if (sum[pfig_pkg::ELAPSED_W]) begin
            step.elapsed_next = pfig_pkg::ELAPSED_MAX;
        end else begin
            step.elapsed_next = sum[pfig_pkg::ELAPSED_W-1:0];
        end
    end

endmodule

[hdl/ppm_frame_interval_generator_core.sv]
// PPM frame interval generator.
//
// The input channel (s_*) carries two kinds of words. A write word (s_kind low)
// loads s_width_value into the width table entry s_channel; entries at or
// beyond CHANNELS are ignored and a write never produces a result. An expiry
// word (s_kind high) tells the block that the current interval has ended, and
// it answers with one result word on the m_* channel: the length in ticks of
// the next interval and the pin level during it. Low gaps of gap_length ticks
// alternate with channel high phases, and after the last channel a sync high
// fills the rest of the frame; m_frame_overrun flags a sync that had no room.
//
// The result of an expiry word sits in the output register in the cycle after
// it is accepted. Throughput is one word per cycle, set by the single output
// register. While the receiver stalls, the held result stays on the m_* ports
// and s_ready stays low until it is taken.
//
// Reset (aresetn low at a clock edge) clears the width table, the channel
// pointer, the elapsed counter and the output valid, and restores frame_length
// to 180000 ticks and gap_length to 4500 ticks. The APB port writes the two
// registers at byte addresses 0 and 4 with no wait states.
module ppm_frame_interval_generator_core #(
    parameter int CHANNELS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfig_pkg::APB_AW-1:0]       paddr,
    input  logic [pfig_pkg::APB_DW-1:0]       pwdata,
    output logic [pfig_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [pfig_pkg::CHAN_W-1:0]       s_channel,
    input  logic [pfig_pkg::TICK_W-1:0]       s_width_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pfig_pkg::TICK_W-1:0]       m_interval_ticks,
    output logic                              m_pin_level,
    output logic                              m_sync_phase,
    output logic                              m_frame_overrun
);

    // The pointer must also hold CHANNELS itself, which marks the sync phase.
    localparam int PTR_W = $clog2(CHANNELS + 1);

    logic [pfig_pkg::TICK_W-1:0]    frame_length_reg;
    logic [pfig_pkg::TICK_W-1:0]    gap_length_reg;
    logic [pfig_pkg::TICK_W-1:0]    width_reg [CHANNELS];
    logic                           high_phase_reg;
    logic [PTR_W-1:0]               ptr_reg;
    logic [PTR_W-1:0]               ptr_next;
    logic [pfig_pkg::ELAPSED_W-1:0] elapsed_reg;

    logic                           m_valid_reg;
    pfig_pkg::result_t              result_reg;

    logic                           s_accept;
    logic                           expire;
    logic                           cfg_write;
    pfig_pkg::reg_idx_t             cfg_idx;
    logic [pfig_pkg::TICK_W-1:0]    chan_width;
    logic                           last_done;
    pfig_pkg::step_t                step;

    // Configuration port: always ready, decoded on the word address bit.
    assign pready    = 1'b1;
    assign cfg_idx   = pfig_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            pfig_pkg::REG_FRAME_LENGTH: prdata = pfig_pkg::APB_DW'(frame_length_reg);
            pfig_pkg::REG_GAP_LENGTH:   prdata = pfig_pkg::APB_DW'(gap_length_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= pfig_pkg::FRAME_RESET;
            gap_length_reg   <= pfig_pkg::GAP_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                pfig_pkg::REG_FRAME_LENGTH: frame_length_reg <= pwdata[pfig_pkg::TICK_W-1:0];
                pfig_pkg::REG_GAP_LENGTH:   gap_length_reg   <= pwdata[pfig_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // A new word is taken whenever the output register is free or being drained.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign expire   = s_accept && (pfig_pkg::kind_t'(s_kind) == pfig_pkg::KIND_EXPIRE);

    // Width table read at the channel pointer.
    always_comb begin
        chan_width = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (int'(ptr_reg) == i) begin
                chan_width = width_reg[i];
            end
        end
    end

    assign last_done = int'(ptr_reg) >= CHANNELS;

    pfig_step u_step (
        .in_high_phase (high_phase_reg),
        .last_done     (last_done),
        .chan_width    (chan_width),
        .elapsed       (elapsed_reg),
        .frame_length  (frame_length_reg),
        .gap_length    (gap_length_reg),
        .step          (step)
    );

    always_comb begin
        priority if (step.ptr_wrap) begin
            ptr_next = '0;
        end else if (step.ptr_advance) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end else begin
            ptr_next = ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                width_reg[i] <= '0;
            end
        end else if (s_accept && (pfig_pkg::kind_t'(s_kind) == pfig_pkg::KIND_WRITE)) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (int'(s_channel) == i) begin
                    width_reg[i] <= s_width_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_phase_reg <= 1'b0;
            ptr_reg        <= '0;
            elapsed_reg    <= '0;
        end else if (expire) begin
            high_phase_reg <= step.high_next;
            ptr_reg        <= ptr_next;
            elapsed_reg    <= step.elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (expire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (expire) begin
            result_reg <= step.res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_interval_ticks = result_reg.interval_ticks;
    assign m_pin_level      = result_reg.pin_level;
    assign m_sync_phase     = result_reg.sync_phase;
    assign m_frame_overrun  = result_reg.frame_overrun;

endmodule

[hdl/pfig_checker.sv]
module pfig_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pfig_pkg::TICK_W-1:0] m_interval_ticks,
    input logic                        m_pin_level,
    input logic                        m_sync_phase,
    input logic                        m_frame_overrun
);

    // No result word may be presented right after reset.
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result word holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_interval_ticks)
                                   && $stable(m_pin_level) && $stable(m_sync_phase)
                                   && $stable(m_frame_overrun)))
        else $error("stalled result word changed");

    // The sync phase is always a high phase.
    a_sync_is_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sync_phase) |-> m_pin_level)
        else $error("sync phase with pin low");

    // An overrun only comes with a sync of zero length.
    a_overrun_zero_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_overrun) |-> (m_sync_phase && (m_interval_ticks == '0)))
        else $error("overrun without a zero-length sync");

endmodule

bind ppm_frame_interval_generator_core pfig_checker u_pfig_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_interval_ticks (m_interval_ticks),
    .m_pin_level      (m_pin_level),
    .m_sync_phase     (m_sync_phase),
    .m_frame_overrun  (m_frame_overrun)
);
